// ----- rtl/pcr_pkg.sv -----
// Shared types, constants and segment tables for the piecewise cubic rigidity unit.
// Coefficient tables are built at elaboration from their decimal forms.
// Used by every module of the unit and by its checker.
package pcr_pkg;

	localparam int TK_W = 17;
	localparam int T_W = 18;
	localparam int X_W = 17;
	localparam int NSEG = 11;
	localparam int SEG_W = 4;
	localparam int RIG_W = 40;
	localparam int LIM_W = 2;

	localparam int A3_W = 41;
	localparam int A2_W = 47;
	localparam int A1S_W = 44;
	localparam int A0S_W = 48;
	localparam int P1_W = A3_W + X_W;
	localparam int H1_W = 50;
	localparam int P2_W = H1_W + X_W;
	localparam int H2_W = 50;
	localparam int P3_W = H2_W + X_W;
	localparam int H3_W = 58;
	localparam int V_W = H3_W - 17;

	localparam logic [TK_W-1:0] TK_MAX = 17'd102399;
	localparam logic signed [T_W-1:0] ZERO_C_Q8 = 18'sd69926;
	localparam logic [RIG_W-1:0] NEG_FILL = 40'd1000000;
	localparam logic [RIG_W-1:0] RIG_MAX = {RIG_W{1'b1}};

	typedef enum logic [LIM_W-1:0] {
		LIM_NONE = 2'd0,
		LIM_NEG  = 2'd1,
		LIM_SAT  = 2'd2
	} lim_t;

	// One classified item passed from the front to the back.
	typedef struct packed {
		logic [SEG_W-1:0]       seg;
		logic signed [X_W-1:0]  x;
	} job_t;

	// value*1e15 to Q24 of value*1e9, rounded half up on the magnitude
	function automatic longint mq(input longint m);
		longint q;
		longint r;
		q = m / 64'sd1000000;
		r = m % 64'sd1000000;
		return q * 64'sd16777216 + (r * 64'sd16777216 + 64'sd500000) / 64'sd1000000;
	endfunction

	localparam logic signed [T_W-1:0] SEG_TOP [NSEG-1] = '{
		-18'sd10240, -18'sd8960, -18'sd7680, -18'sd6400, -18'sd5120,
		-18'sd3840, -18'sd2560, -18'sd1280, -18'sd512, -18'sd256
	};

	localparam logic signed [T_W-1:0] SEG_SHIFT [NSEG] = '{
		18'sd12800, 18'sd10240, 18'sd8960, 18'sd7680, 18'sd6400, 18'sd5120,
		18'sd3840, 18'sd2560, 18'sd1280, 18'sd512, 18'sd256
	};

	localparam logic signed [A3_W-1:0] A3_TAB [NSEG] = '{
		A3_W'(-mq(64'sd31098521204)),
		A3_W'(-mq(64'sd31098521204)),
		A3_W'(-mq(64'sd38394040864)),
		A3_W'(-mq(64'sd7037062330)),
		A3_W'(mq(64'sd905055684)),
		A3_W'(-mq(64'sd2025865930)),
		A3_W'(-mq(64'sd14464671112)),
		A3_W'(-mq(64'sd14230086582)),
		A3_W'(mq(64'sd22694046251)),
		A3_W'(mq(64'sd56280347425)),
		A3_W'(mq(64'sd56280347425))
	};

	localparam logic signed [A2_W-1:0] A2_TAB [NSEG] = '{
		A2_W'(mq(64'sd2234792114381)),
		A2_W'(mq(64'sd1301836478264)),
		A2_W'(mq(64'sd835358660205)),
		A2_W'(mq(64'sd259448047242)),
		A2_W'(mq(64'sd153892112291)),
		A2_W'(mq(64'sd167467947546)),
		A2_W'(mq(64'sd137079958603)),
		A2_W'(-mq(64'sd79890108083)),
		A2_W'(-mq(64'sd293341406806)),
		A2_W'(-mq(64'sd89094990549)),
		A2_W'(mq(64'sd79746051725))
	};

	// Linear and constant terms are stored already floored to Q16.
	localparam logic signed [A1S_W-1:0] A1S_TAB [NSEG] = '{
		A1S_W'(-mq(64'sd65051516643164) >>> 8),
		A1S_W'(-mq(64'sd29685230716715) >>> 8),
		A1S_W'(-mq(64'sd18999255024368) >>> 8),
		A1S_W'(-mq(64'sd13525221487131) >>> 8),
		A1S_W'(-mq(64'sd11458520689465) >>> 8),
		A1S_W'(-mq(64'sd9851720390281) >>> 8),
		A1S_W'(-mq(64'sd8328980859537) >>> 8),
		A1S_W'(-mq(64'sd8043031606935) >>> 8),
		A1S_W'(-mq(64'sd9909189181377) >>> 8),
		A1S_W'(-mq(64'sd11056498373441) >>> 8),
		A1S_W'(-mq(64'sd11065847312265) >>> 8)
	};

	localparam logic signed [A0S_W-1:0] A0S_TAB [NSEG] = '{
		A0S_W'(mq(64'sd1005181071430026) >>> 8),
		A0S_W'(mq(64'sd547046595232583) >>> 8),
		A0S_W'(mq(64'sd427279038455119) >>> 8),
		A0S_W'(mq(64'sd348367474730384) >>> 8),
		A0S_W'(mq(64'sd286347935684521) >>> 8),
		A0S_W'(mq(64'sd233015767004928) >>> 8),
		A0S_W'(mq(64'sd187690630500981) >>> 8),
		A0S_W'(mq(64'sd147664641279324) >>> 8),
		A0S_W'(mq(64'sd103673469719891) >>> 8),
		A0S_W'(mq(64'sd71918568763277) >>> 8),
		A0S_W'(mq(64'sd60829255746712) >>> 8)
	};

endpackage

// ----- rtl/pcr_in_if.sv -----
// Input channel of the rigidity unit: temperature items with valid/ready.
// Depends on pcr_pkg for field widths.
interface pcr_in_if;
	logic                        valid;
	logic                        ready;
	logic [pcr_pkg::TK_W-1:0]    temperature_kelvin;

	modport source (output valid, output temperature_kelvin, input ready);
	modport sink (input valid, input temperature_kelvin, output ready);
endinterface

// ----- rtl/pcr_out_if.sv -----
// Output channel of the rigidity unit: rigidity and limit flag with valid/ready.
// Depends on pcr_pkg for field widths.
interface pcr_out_if;
	logic                        valid;
	logic                        ready;
	logic [pcr_pkg::RIG_W-1:0]   rigidity;
	logic [pcr_pkg::LIM_W-1:0]   limited;

	modport source (output valid, output rigidity, output limited, input ready);
	modport sink (input valid, input rigidity, input limited, output ready);
endinterface

// ----- rtl/pcr_front.sv -----
// Front end: accepts temperatures, converts to Celsius, picks the segment and knot offset.
// Depends on pcr_pkg and pcr_in_if; feeds pcr_queue.
module pcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pcr_in_if.sink               temp_in,
	output logic                 push_valid,
	input  logic                 push_ready,
	output pcr_pkg::job_t        push_data
);

	logic [pcr_pkg::TK_W-1:0]          tk_clamp;
	logic signed [pcr_pkg::T_W-1:0]    t_c;
	logic [pcr_pkg::SEG_W-1:0]         seg_c;
	logic signed [pcr_pkg::T_W-1:0]    x_full;
	pcr_pkg::job_t                     job_c;
	pcr_pkg::job_t                     job_q;
	logic                              job_valid_q;
	logic                              take;

	always_comb begin
		tk_clamp = (temp_in.temperature_kelvin > pcr_pkg::TK_MAX) ?
			pcr_pkg::TK_MAX : temp_in.temperature_kelvin;
		t_c = $signed({1'b0, tk_clamp}) - pcr_pkg::ZERO_C_Q8;
		seg_c = pcr_pkg::SEG_W'(pcr_pkg::NSEG - 1);
		// lowest matching bound wins
		for (int i = pcr_pkg::NSEG - 2; i >= 0; i--) begin
			if (t_c <= pcr_pkg::SEG_TOP[i]) begin
				seg_c = pcr_pkg::SEG_W'(i);
			end
		end
		x_full = t_c + pcr_pkg::SEG_SHIFT[seg_c];
		job_c.seg = seg_c;
		job_c.x = x_full[pcr_pkg::X_W-1:0];
	end

	assign temp_in.ready = !job_valid_q || push_ready;
	assign take = temp_in.valid && temp_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (temp_in.ready) begin
			job_valid_q <= temp_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job_c;
		end
	end

	assign push_valid = job_valid_q;
	assign push_data = job_q;

endmodule

// ----- rtl/pcr_queue.sv -----
// Short FIFO of classified items between the front and the back.
// Depends on pcr_pkg for the entry type.
module pcr_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  pcr_pkg::job_t        push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output pcr_pkg::job_t        pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcr_pkg::job_t        mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/pcr_back.sv -----
// Back end: Horner evaluation of the segment cubic, then limit and output register.
// Depends on pcr_pkg and pcr_out_if; drains pcr_queue.
module pcr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  pcr_pkg::job_t        pop_data,
	pcr_out_if.source            rig_out
);

	logic advance;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic out_valid_q;

	logic [pcr_pkg::SEG_W-1:0]         seg_s1, seg_s2, seg_s3, seg_s4, seg_s5, seg_s6;
	logic signed [pcr_pkg::X_W-1:0]    x_s1, x_s2, x_s3, x_s4, x_s5;
	logic signed [pcr_pkg::P1_W-1:0]   p1_s2;
	logic signed [pcr_pkg::H1_W-1:0]   h1_s3;
	logic signed [pcr_pkg::P2_W-1:0]   p2_s4;
	logic signed [pcr_pkg::H2_W-1:0]   h2_s5;
	logic signed [pcr_pkg::P3_W-1:0]   p3_s6;
	logic signed [pcr_pkg::H3_W-1:0]   h3_s7;
	logic [pcr_pkg::RIG_W-1:0]         rigidity_q;
	pcr_pkg::lim_t                     limited_q;

	logic signed [pcr_pkg::P1_W-1:0]   p1_c;
	logic signed [pcr_pkg::H1_W-1:0]   h1_c;
	logic signed [pcr_pkg::P2_W-1:0]   p2_c;
	logic signed [pcr_pkg::H2_W-1:0]   h2_c;
	logic signed [pcr_pkg::P3_W-1:0]   p3_c;
	logic signed [pcr_pkg::H3_W-1:0]   h3_c;
	logic [pcr_pkg::V_W-1:0]           v_c;
	logic [pcr_pkg::RIG_W-1:0]         rig_c;
	pcr_pkg::lim_t                     lim_c;

	// whole pipe moves together; freeze only while the output item is held
	assign advance = !out_valid_q || rig_out.ready;
	assign pop_ready = advance;

	always_comb begin
		p1_c = pcr_pkg::P1_W'(pcr_pkg::A3_TAB[seg_s1]) * pcr_pkg::P1_W'(x_s1);
		h1_c = pcr_pkg::H1_W'(p1_s2 >>> 8) + pcr_pkg::H1_W'(pcr_pkg::A2_TAB[seg_s2]);
		p2_c = pcr_pkg::P2_W'(h1_s3) * pcr_pkg::P2_W'(x_s3);
		h2_c = pcr_pkg::H2_W'(p2_s4 >>> 16) + pcr_pkg::H2_W'(pcr_pkg::A1S_TAB[seg_s4]);
		p3_c = pcr_pkg::P3_W'(h2_s5) * pcr_pkg::P3_W'(x_s5);
		h3_c = pcr_pkg::H3_W'(p3_s6 >>> 8) + pcr_pkg::H3_W'(pcr_pkg::A0S_TAB[seg_s6]);
		v_c = h3_s7[pcr_pkg::H3_W-2:16];
		if (h3_s7[pcr_pkg::H3_W-1]) begin
			rig_c = pcr_pkg::NEG_FILL;
			lim_c = pcr_pkg::LIM_NEG;
		end else if ((pcr_pkg::RIG_W + 1)'(v_c) > (pcr_pkg::RIG_W + 1)'(pcr_pkg::RIG_MAX)) begin
			rig_c = pcr_pkg::RIG_MAX;
			lim_c = pcr_pkg::LIM_SAT;
		end else begin
			rig_c = pcr_pkg::RIG_W'(v_c);
			lim_c = pcr_pkg::LIM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s1 <= pop_data.seg;
			x_s1 <= pop_data.x;
			seg_s2 <= seg_s1;
			x_s2 <= x_s1;
			p1_s2 <= p1_c;
			seg_s3 <= seg_s2;
			x_s3 <= x_s2;
			h1_s3 <= h1_c;
			seg_s4 <= seg_s3;
			x_s4 <= x_s3;
			p2_s4 <= p2_c;
			seg_s5 <= seg_s4;
			x_s5 <= x_s4;
			h2_s5 <= h2_c;
			seg_s6 <= seg_s5;
			p3_s6 <= p3_c;
			h3_s7 <= h3_c;
			rigidity_q <= rig_c;
			limited_q <= lim_c;
		end
	end

	assign rig_out.valid = out_valid_q;
	assign rig_out.rigidity = rigidity_q;
	assign rig_out.limited = limited_q;

endmodule

// ----- rtl/piecewise_cubic_rigidity_unit.sv -----
// Piecewise cubic ice rigidity unit.
// temp_in carries a kelvin temperature in unsigned Q8; rig_out carries the rigidity
// in whole Pa*s^(1/3) and a two-bit flag (0 none, 1 negative replaced, 2 saturated).
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// The front stage clamps the input, converts to Celsius and picks one of eleven
// segments; a short queue hands the segment and knot offset to the back end.
// The back end is a seven-stage Horner pipeline with three multipliers and a
// registered output, so while the receiver keeps ready high one item is accepted
// every cycle and one result leaves every cycle. Each item passes the front register,
// the queue, the Horner stages and the output register. Asynchronous reset empties
// the front stage, the queue and the pipeline; no result is offered until new items
// arrive. When the receiver holds ready low while a result is offered, the output and
// the back pipeline freeze; the front keeps taking items into the queue until it holds
// QUEUE_DEPTH entries and the front stage is full, then temp_in.ready drops.
module piecewise_cubic_rigidity_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	pcr_in_if.sink    temp_in,
	pcr_out_if.source rig_out
);

	logic             push_valid;
	logic             push_ready;
	pcr_pkg::job_t    push_data;
	logic             pop_valid;
	logic             pop_ready;
	pcr_pkg::job_t    pop_data;

	pcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.temp_in    (temp_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rig_out   (rig_out)
	);

endmodule

// ----- rtl/pcr_checker.sv -----
// Port-level checks of the rigidity unit, attached to the top level by bind.
// Depends on pcr_pkg for widths and flag codes.
module pcr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [pcr_pkg::RIG_W-1:0]  rigidity,
	input logic [pcr_pkg::LIM_W-1:0]  limited
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rigidity) && $stable(limited))
		else $error("result changed while stalled");

	a_neg_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limited == pcr_pkg::LIM_NEG |-> rigidity == pcr_pkg::NEG_FILL)
		else $error("negative flag without fill value");

	a_sat_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limited == pcr_pkg::LIM_SAT |-> rigidity == pcr_pkg::RIG_MAX)
		else $error("saturation flag without top value");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered right after reset");

endmodule

bind piecewise_cubic_rigidity_unit pcr_checker u_pcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rig_out.valid),
	.out_ready (rig_out.ready),
	.rigidity  (rig_out.rigidity),
	.limited   (rig_out.limited)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_cubic_rigidity_unit: temperature items in, rigidity
// items out, each result checked against a Horner predictor kept in the testbench.
// Depends on pcr_pkg, pcr_in_if, pcr_out_if and the unit itself.
module testbench;

	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 90;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_TEMPS = 1125;
	localparam longint KELVIN_ZERO_Q8 = 69926;
	localparam longint KELVIN_TOP_Q8 = 102399;
	localparam longint FILL_NEG = 1000000;
	localparam longint RIG_TOP = 64'd1099511627775;

	typedef struct {
		logic [pcr_pkg::TK_W-1:0]  temp;
		logic [pcr_pkg::RIG_W-1:0] rig;
		pcr_pkg::lim_t             lim;
	} rigidity_t;

	// Upper Celsius bound of each segment but the last, and the knot shift of each, Q8.
	longint knot_top [0:9] = '{-10240, -8960, -7680, -6400, -5120, -3840, -2560, -1280,
		-512, -256};
	longint knot_shift [0:10] = '{12800, 10240, 8960, 7680, 6400, 5120, 3840, 2560, 1280,
		512, 256};

	// Cubic, quadratic, linear and constant terms, value*1e15 (signed).
	longint coef_micro [0:10][0:3] = '{
		'{-64'sd31098521204, 64'sd2234792114381, -64'sd65051516643164, 64'sd1005181071430026},
		'{-64'sd31098521204, 64'sd1301836478264, -64'sd29685230716715, 64'sd547046595232583},
		'{-64'sd38394040864, 64'sd835358660205, -64'sd18999255024368, 64'sd427279038455119},
		'{-64'sd7037062330, 64'sd259448047242, -64'sd13525221487131, 64'sd348367474730384},
		'{64'sd905055684, 64'sd153892112291, -64'sd11458520689465, 64'sd286347935684521},
		'{-64'sd2025865930, 64'sd167467947546, -64'sd9851720390281, 64'sd233015767004928},
		'{-64'sd14464671112, 64'sd137079958603, -64'sd8328980859537, 64'sd187690630500981},
		'{-64'sd14230086582, -64'sd79890108083, -64'sd8043031606935, 64'sd147664641279324},
		'{64'sd22694046251, -64'sd293341406806, -64'sd9909189181377, 64'sd103673469719891},
		'{64'sd56280347425, -64'sd89094990549, -64'sd11056498373441, 64'sd71918568763277},
		'{64'sd56280347425, 64'sd79746051725, -64'sd11065847312265, 64'sd60829255746712}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic drv_valid = 1'b0;
	logic [pcr_pkg::TK_W-1:0] drv_temp = '0;
	logic mon_ready = 1'b0;

	pcr_in_if temp_ch ();
	pcr_out_if rig_ch ();

	assign temp_ch.valid = drv_valid;
	assign temp_ch.temperature_kelvin = drv_temp;
	assign rig_ch.ready = mon_ready;

	piecewise_cubic_rigidity_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.temp_in(temp_ch),
		.rig_out(rig_ch)
	);

	logic [pcr_pkg::TK_W-1:0] temps_pending [$];
	rigidity_t rigidity_due [$];
	int temps_total = 0;
	int temps_sent = 0;
	int results_popped = 0;
	int mismatches = 0;
	int clamped_temps = 0;
	int neg_filled = 0;
	int saturated = 0;
	logic [pcr_pkg::NSEG-1:0] seg_hit = '0;
	int drv_gap = 0;
	int stall_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Round value*1e15 to Q24 of value*1e9, half away from zero.
	function automatic longint q24_of(input longint micro);
		longint mag;
		mag = (micro < 0) ? -micro : micro;
		mag = (mag / 64'sd1000000) * 64'sd16777216
			+ ((mag % 64'sd1000000) * 64'sd16777216 + 64'sd500000) / 64'sd1000000;
		return (micro < 0) ? -mag : mag;
	endfunction

	function automatic void predict_rigidity(input logic [pcr_pkg::TK_W-1:0] tk,
			output logic [pcr_pkg::RIG_W-1:0] rig, output pcr_pkg::lim_t lim,
			output int seg);
		longint t;
		longint x;
		longint h1;
		longint h2;
		longint h3;
		longint whole;
		t = (longint'(tk) > KELVIN_TOP_Q8) ? KELVIN_TOP_Q8 : longint'(tk);
		t = t - KELVIN_ZERO_Q8;
		seg = pcr_pkg::NSEG - 1;
		// bounds rise with the index, so the lowest matching one wins
		for (int i = pcr_pkg::NSEG - 2; i >= 0; i--)
			if (t <= knot_top[i])
				seg = i;
		x = t + knot_shift[seg];
		h1 = ((q24_of(coef_micro[seg][0]) * x) >>> 8) + q24_of(coef_micro[seg][1]);
		h2 = ((h1 * x) >>> 16) + (q24_of(coef_micro[seg][2]) >>> 8);
		h3 = ((h2 * x) >>> 8) + (q24_of(coef_micro[seg][3]) >>> 8);
		if (h3 < 0) begin
			rig = pcr_pkg::RIG_W'(FILL_NEG);
			lim = pcr_pkg::LIM_NEG;
		end else begin
			whole = h3 >>> 16;
			if (whole > RIG_TOP) begin
				rig = pcr_pkg::RIG_W'(RIG_TOP);
				lim = pcr_pkg::LIM_SAT;
			end else begin
				rig = pcr_pkg::RIG_W'(whole);
				lim = pcr_pkg::LIM_NONE;
			end
		end
	endfunction

	// Sender gap before the next item: bursts and the hold window send back to back.
	function automatic int sender_gap(input int n);
		if (((n % 300) >= 150 && (n % 300) < 220) || (n >= HOLD_AT && n < HOLD_AT + 80))
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic int receiver_stall(input int n);
		if ((n % 256) >= 64 && (n % 256) < 128)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Driver: present one item at a time, hold it until taken.
	always @(posedge clk or negedge arst_n) begin : drive
		logic [pcr_pkg::RIG_W-1:0] exp_rig;
		pcr_pkg::lim_t exp_lim;
		int exp_seg;
		rigidity_t due;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_temp <= '0;
			drv_gap = 0;
		end else begin
			if (drv_valid && temp_ch.ready === 1'b1) begin
				predict_rigidity(drv_temp, exp_rig, exp_lim, exp_seg);
				due.temp = drv_temp;
				due.rig = exp_rig;
				due.lim = exp_lim;
				rigidity_due.push_back(due);
				seg_hit[exp_seg] = 1'b1;
				if (longint'(drv_temp) > KELVIN_TOP_Q8)
					clamped_temps++;
				if (exp_lim == pcr_pkg::LIM_NEG)
					neg_filled++;
				if (exp_lim == pcr_pkg::LIM_SAT)
					saturated++;
				temps_sent++;
				drv_gap = sender_gap(temps_sent);
			end
			if (drv_valid && temp_ch.ready !== 1'b1) begin
				// hold the offered item
			end else if (drv_gap > 0) begin
				drv_gap--;
				drv_valid <= 1'b0;
			end else if (temps_pending.size() > 0) begin
				drv_valid <= 1'b1;
				drv_temp <= temps_pending.pop_front();
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Monitor: take results, compare with the oldest prediction, stall at random.
	always @(posedge clk or negedge arst_n) begin : watch
		rigidity_t due;
		if (!arst_n) begin
			mon_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rig_ch.valid === 1'b1 && mon_ready) begin
				if (rigidity_due.size() == 0) begin
					note_mismatch($sformatf("unexpected item rigidity=%0d limited=%0d",
						rig_ch.rigidity, rig_ch.limited));
				end else begin
					due = rigidity_due.pop_front();
					results_popped++;
					if (rig_ch.rigidity !== due.rig || rig_ch.limited !== due.lim)
						note_mismatch($sformatf(
							"temp=%0d expected rigidity=%0d limited=%0d, got %0d/%0d",
							due.temp, due.rig, due.lim, rig_ch.rigidity, rig_ch.limited));
				end
				stall_left = receiver_stall(results_popped);
			end
			// long hold so the unit backs up and drops its input ready
			if (!hold_done && temps_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				mon_ready <= 1'b0;
			end else begin
				mon_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (drv_valid && temp_ch.ready === 1'b1)
				|| (rig_ch.valid === 1'b1 && mon_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout with %0d results outstanding", rigidity_due.size());
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		longint tk;
		int pick;
		int k;
		// range extremes, zero Celsius, and both sides of every segment bound
		temps_pending.push_back(pcr_pkg::TK_W'(0));
		temps_pending.push_back(pcr_pkg::TK_W'(KELVIN_TOP_Q8));
		temps_pending.push_back(pcr_pkg::TK_W'(KELVIN_TOP_Q8 + 1));
		temps_pending.push_back({pcr_pkg::TK_W{1'b1}});
		temps_pending.push_back(pcr_pkg::TK_W'(KELVIN_ZERO_Q8));
		for (int i = 0; i < pcr_pkg::NSEG - 1; i++) begin
			temps_pending.push_back(pcr_pkg::TK_W'(KELVIN_ZERO_Q8 + knot_top[i]));
			temps_pending.push_back(pcr_pkg::TK_W'(KELVIN_ZERO_Q8 + knot_top[i] + 1));
		end
		for (int n = 0; n < RANDOM_TEMPS; n++) begin
			pick = $urandom_range(0, 15);
			if (pick < 2) begin
				tk = $urandom_range(KELVIN_TOP_Q8 + 1, (1 << pcr_pkg::TK_W) - 1);
			end else if (pick < 6) begin
				k = $urandom_range(0, pcr_pkg::NSEG - 2);
				tk = KELVIN_ZERO_Q8 + knot_top[k] + $urandom_range(0, 8) - 4;
			end else if (pick < 8) begin
				tk = $urandom_range(0, (1 << pcr_pkg::TK_W) - 1);
			end else begin
				tk = $urandom_range(0, KELVIN_TOP_Q8);
			end
			temps_pending.push_back(pcr_pkg::TK_W'(tk));
		end
		temps_total = temps_pending.size();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (temps_sent == temps_total && results_popped == temps_total);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d rigidity items across %0d of %0d segments, %0d above range.",
			results_popped, $countones(seg_hit), pcr_pkg::NSEG, clamped_temps);
		$display("Limit flags predicted: %0d negative fill, %0d saturation; %0d mismatches.",
			neg_filled, saturated, mismatches);
		if (mismatches == 0 && rigidity_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
